/* src/solenoidal_projection_kspace_defines.svh */
// assertion macros for the solenoidal projection block
`ifndef SOLENOIDAL_PROJECTION_KSPACE_DEFINES_SVH
`define SOLENOIDAL_PROJECTION_KSPACE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked on every rising edge outside reset
`define SPK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// property whose consequent is checked in the cycle after its antecedent
`define SPK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define SPK_ASSERT(lbl, prop, msg)
`define SPK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* src/spk_pkg.sv */
`timescale 1ns / 1ps

package spk_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int INDEX_BITS   = 10;
  localparam int GRID_BITS    = 11;
  localparam int SPACING_BITS = 16;
  localparam int GRID_MAX     = 1024;
  localparam int AXES         = 3;
  localparam int LANES        = 2 * AXES;

  // arithmetic widths
  localparam int WN_BITS     = GRID_BITS;
  localparam int KW_BITS     = WN_BITS + SPACING_BITS + 1;
  localparam int K_BITS      = 27;
  localparam int KMAG_BITS   = K_BITS - 1;
  localparam int KF_BITS     = K_BITS + SAMPLE_BITS;
  localparam int KSQ_BITS    = 2 * KMAG_BITS;
  localparam int DOT_BITS    = KF_BITS + 2;
  localparam int DOTMAG_BITS = DOT_BITS - 1;
  localparam int HALF_BITS   = KMAG_BITS;
  localparam int PP_BITS     = 2 * KMAG_BITS;
  localparam int DEN_BITS    = KSQ_BITS + 2;
  localparam int NUM_BITS    = KMAG_BITS + DOTMAG_BITS + 1;
  localparam int DIV_BITS    = DEN_BITS + 1;
  localparam int QUO_BITS    = SAMPLE_BITS + 1;
  localparam int CO_BITS     = QUO_BITS + 1;
  localparam int SH_BITS     = CO_BITS + 1;

  // pipeline layout
  localparam int FRONT_STAGES = 4;
  localparam int MUL_STAGES   = 2;
  localparam int DIV_STEPS    = QUO_BITS;
  localparam int NSTAGE       = FRONT_STAGES + MUL_STAGES + DIV_STEPS + 1;

  // configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = SPACING_BITS;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GRID_X    = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GRID_Y    = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GRID_Z    = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPACING_X = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPACING_Y = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPACING_Z = 3'd5;
  localparam logic [GRID_BITS-1:0]    GRID_RESET    = 11'd64;
  localparam logic [SPACING_BITS-1:0] SPACING_RESET = 16'd4096;

  typedef struct packed {
    logic [INDEX_BITS-1:0]  index_x;
    logic [INDEX_BITS-1:0]  index_y;
    logic [INDEX_BITS-1:0]  index_z;
    logic signed [SAMPLE_BITS-1:0] vec_x_re;
    logic signed [SAMPLE_BITS-1:0] vec_x_im;
    logic signed [SAMPLE_BITS-1:0] vec_y_re;
    logic signed [SAMPLE_BITS-1:0] vec_y_im;
    logic signed [SAMPLE_BITS-1:0] vec_z_re;
    logic signed [SAMPLE_BITS-1:0] vec_z_im;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sol_x_re;
    logic signed [SAMPLE_BITS-1:0] sol_x_im;
    logic signed [SAMPLE_BITS-1:0] sol_y_re;
    logic signed [SAMPLE_BITS-1:0] sol_y_im;
    logic signed [SAMPLE_BITS-1:0] sol_z_re;
    logic signed [SAMPLE_BITS-1:0] sol_z_im;
    logic signed [SAMPLE_BITS-1:0] comp_x_re;
    logic signed [SAMPLE_BITS-1:0] comp_x_im;
    logic signed [SAMPLE_BITS-1:0] comp_y_re;
    logic signed [SAMPLE_BITS-1:0] comp_y_im;
    logic signed [SAMPLE_BITS-1:0] comp_z_re;
    logic signed [SAMPLE_BITS-1:0] comp_z_im;
  } out_item_t;

  // lane l: axis l/2, real part when l is even
  typedef logic [LANES-1:0][SAMPLE_BITS-1:0] vec_t;

  typedef struct packed {
    logic [AXES-1:0][K_BITS-1:0] k;
    logic [1:0][DOT_BITS-1:0]    dot;
    logic [DEN_BITS-1:0]         den;
    vec_t                        f;
  } front_t;

  typedef struct packed {
    logic [LANES-1:0][NUM_BITS-1:0] num;
    logic [LANES-1:0]               neg;
    logic [DIV_BITS-1:0]            d;
    logic                           dzero;
    vec_t                           f;
  } div_in_t;

  typedef struct packed {
    logic [LANES-1:0][QUO_BITS-1:0] q;
    logic [LANES-1:0]               neg;
    logic                           dzero;
    vec_t                           f;
  } div_out_t;

  function automatic logic [SAMPLE_BITS-1:0] saturate(input logic [SH_BITS-1:0] x);
    logic [SH_BITS-SAMPLE_BITS:0] top;
    top = x[SH_BITS-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      return x[SAMPLE_BITS-1:0];
    end else if (x[SH_BITS-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

/* src/solenoidal_projection_kspace.sv */
`timescale 1ns / 1ps

// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------
// input    | in_valid_i/in_stall_o   | in_data_i: grid indices, vector f
// output   | out_valid_o/out_stall_i | out_data_o: solenoidal, compressive
// config   | cfg_we_i                | cfg_addr_i, cfg_wdata_i
//
// one transfer per cycle sustained while out_stall_i is low; 32 register stages: 4 front, 2 multiply,
// 25 divider, 1 output
// the 25-stage restoring divider (one quotient bit per stage) sets the depth
// reset clears valid bits and loads grid size 64, spacing 1.0 on all axes
// stalls collapse bubbles: an input transfer is taken whenever any stage is empty

`include "solenoidal_projection_kspace_defines.svh"

module solenoidal_projection_kspace import spk_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_item_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_item_t                out_data_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i
);

  // configuration registers
  logic [AXES-1:0][GRID_BITS-1:0]    grid_q;
  logic [AXES-1:0][SPACING_BITS-1:0] spacing_q;

  // pipeline occupancy
  logic [NSTAGE-1:0] v_q, v_d, rdy, ld;
  logic              acc_in, acc_out;

  front_t   front;
  div_in_t  div_in;
  div_out_t div_out;

  logic [LANES-1:0][CO_BITS-1:0]     co;
  logic [LANES-1:0][SH_BITS-1:0]     sh;
  logic [LANES-1:0][SAMPLE_BITS-1:0] comp, sol;
  logic [LANES-1:0]                  q_msb;
  out_item_t                         out_d, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        grid_q[a]    <= GRID_RESET;
        spacing_q[a] <= SPACING_RESET;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_GRID_X:    grid_q[0]    <= cfg_wdata_i[GRID_BITS-1:0];
        REG_GRID_Y:    grid_q[1]    <= cfg_wdata_i[GRID_BITS-1:0];
        REG_GRID_Z:    grid_q[2]    <= cfg_wdata_i[GRID_BITS-1:0];
        REG_SPACING_X: spacing_q[0] <= cfg_wdata_i;
        REG_SPACING_Y: spacing_q[1] <= cfg_wdata_i;
        REG_SPACING_Z: spacing_q[2] <= cfg_wdata_i;
        default: ;  // unused indexes ignored
      endcase
    end
  end

  // a stage can take new data if it is empty or its content moves on;
  // a full stage that cannot move holds both its valid bit and its payload
  always_comb begin
    rdy[NSTAGE-1] = !v_q[NSTAGE-1] || !out_stall_i;
    for (int s = NSTAGE - 2; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
    ld[0] = in_valid_i && rdy[0];
    for (int s = 1; s < NSTAGE; s++) begin
      ld[s] = v_q[s-1] && rdy[s];
    end
    v_d = ld | (v_q & ~rdy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NSTAGE-1];
  assign acc_in      = in_valid_i && !in_stall_o;
  assign acc_out     = out_valid_o && !out_stall_i;

  // wavenumber fold, scaling, k.f and |k|^2
  spk_front u_front (
    .clk_i     (clk_i),
    .ld_i      (ld[FRONT_STAGES-1:0]),
    .in_i      (in_data_i),
    .grid_i    (grid_q),
    .spacing_i (spacing_q),
    .out_o     (front)
  );

  // |k_a||k.f| in split partial products, then the rounding numerator
  spk_mulsplit u_mul (
    .clk_i (clk_i),
    .ld_i  (ld[FRONT_STAGES +: MUL_STAGES]),
    .in_i  (front),
    .out_o (div_in)
  );

  // floor((2|k_a||k.f| + den) / 2den) gives round half away from zero
  spk_divider u_div (
    .clk_i (clk_i),
    .ld_i  (ld[FRONT_STAGES+MUL_STAGES +: DIV_STEPS]),
    .in_i  (div_in),
    .out_o (div_out)
  );

  // sign restore, subtraction and saturation into the output register
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      q_msb[l] = div_out.q[l][QUO_BITS-1];
      if (div_out.dzero) begin
        co[l] = '0;
        sh[l] = '0;
      end else begin
        co[l] = div_out.neg[l] ? (CO_BITS'(0) - CO_BITS'(div_out.q[l]))
                               : CO_BITS'(div_out.q[l]);
        sh[l] = $signed(div_out.f[l]) - $signed(co[l]);
      end
      comp[l] = saturate(SH_BITS'($signed(co[l])));
      sol[l]  = saturate(sh[l]);
    end
    out_d.sol_x_re  = sol[0];
    out_d.sol_x_im  = sol[1];
    out_d.sol_y_re  = sol[2];
    out_d.sol_y_im  = sol[3];
    out_d.sol_z_re  = sol[4];
    out_d.sol_z_im  = sol[5];
    out_d.comp_x_re = comp[0];
    out_d.comp_x_im = comp[1];
    out_d.comp_y_re = comp[2];
    out_d.comp_y_im = comp[3];
    out_d.comp_z_re = comp[4];
    out_d.comp_z_im = comp[5];
  end

  always_ff @(posedge clk_i) begin
    if (ld[NSTAGE-1]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // items in flight change only by transfers on the two channels
  `SPK_ASSERT_NEXT(a_occupancy, 1'b1, ($countones(v_q) + $past(32'(acc_out))) == ($past($countones(v_q)) + $past(32'(acc_in))), "pipeline occupancy mismatch")
  // an empty stage anywhere lets the input through
  `SPK_ASSERT(a_no_idle_stall, !(&v_q) |-> !in_stall_o, "input stalled with a free stage")
  // a valid divider result with a nonzero divisor has its quotient MSB clear
  `SPK_ASSERT(a_quot_range, (v_q[NSTAGE-2] && !div_out.dzero) |-> (q_msb == '0), "quotient out of range")

endmodule

/* src/spk_front.sv */
`timescale 1ns / 1ps

module spk_front import spk_pkg::*; (
  input  logic                                  clk_i,
  input  logic [FRONT_STAGES-1:0]               ld_i,
  input  in_item_t                              in_i,
  input  logic [AXES-1:0][GRID_BITS-1:0]        grid_i,
  input  logic [AXES-1:0][SPACING_BITS-1:0]     spacing_i,
  output front_t                                out_o
);

  logic [AXES-1:0][INDEX_BITS-1:0] idx;
  vec_t                            fin;
  logic [AXES-1:0][GRID_BITS-1:0]  gsz;

  logic [AXES-1:0][WN_BITS-1:0]    wn_d, wn_q;
  vec_t                            f0_q, f1_q, f2_q, f3_q;
  logic [AXES-1:0][KW_BITS-1:0]    kw;
  logic [AXES-1:0][K_BITS-1:0]     k1_q, k2_q, k3_q;
  logic [AXES-1:0][KMAG_BITS-1:0]  kmag;
  logic [AXES-1:0][K_BITS-1:0]     kabs;
  logic [AXES-1:0][1:0][KF_BITS-1:0] kf_d, kf_q;
  logic [AXES-1:0][KSQ_BITS-1:0]   ksq_d, ksq_q;
  logic [1:0][DOT_BITS-1:0]        dot_d, dot_q;
  logic [DEN_BITS-1:0]             den_d, den_q;

  assign idx = {in_i.index_z, in_i.index_y, in_i.index_x};
  assign fin = {in_i.vec_z_im, in_i.vec_z_re, in_i.vec_y_im,
                in_i.vec_y_re, in_i.vec_x_im, in_i.vec_x_re};

  // fold grid index to signed wavenumber
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      gsz[a] = (grid_i[a] > GRID_BITS'(GRID_MAX)) ? GRID_BITS'(GRID_MAX) : grid_i[a];
      if ({idx[a], 1'b0} < gsz[a]) begin
        wn_d[a] = WN_BITS'({1'b0, idx[a]});
      end else begin
        wn_d[a] = WN_BITS'({1'b0, idx[a]} - gsz[a]);
      end
    end
  end

  // scale, products, sums
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      kw[a]   = $signed(wn_q[a]) * $signed({1'b0, spacing_i[a]});
      kabs[a] = k1_q[a][K_BITS-1] ? (K_BITS'(0) - k1_q[a]) : k1_q[a];
      kmag[a] = kabs[a][KMAG_BITS-1:0];
      ksq_d[a] = kmag[a] * kmag[a];
      for (int p = 0; p < 2; p++) begin
        kf_d[a][p] = $signed(k1_q[a]) * $signed(f1_q[2*a+p]);
      end
    end
    for (int p = 0; p < 2; p++) begin
      dot_d[p] = $signed(kf_q[0][p]) + $signed(kf_q[1][p]) + $signed(kf_q[2][p]);
    end
    den_d = DEN_BITS'(ksq_q[0]) + DEN_BITS'(ksq_q[1]) + DEN_BITS'(ksq_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      wn_q <= wn_d;
      f0_q <= fin;
    end
    if (ld_i[1]) begin
      for (int a = 0; a < AXES; a++) begin
        k1_q[a] <= kw[a][K_BITS-1:0];
      end
      f1_q <= f0_q;
    end
    if (ld_i[2]) begin
      kf_q  <= kf_d;
      ksq_q <= ksq_d;
      k2_q  <= k1_q;
      f2_q  <= f1_q;
    end
    if (ld_i[3]) begin
      dot_q <= dot_d;
      den_q <= den_d;
      k3_q  <= k2_q;
      f3_q  <= f2_q;
    end
  end

  assign out_o.k   = k3_q;
  assign out_o.dot = dot_q;
  assign out_o.den = den_q;
  assign out_o.f   = f3_q;

endmodule

/* src/spk_mulsplit.sv */
`timescale 1ns / 1ps

module spk_mulsplit import spk_pkg::*; (
  input  logic                  clk_i,
  input  logic [MUL_STAGES-1:0] ld_i,
  input  front_t                in_i,
  output div_in_t               out_o
);

  logic [AXES-1:0][K_BITS-1:0]      kabs;
  logic [1:0][DOT_BITS-1:0]         dabs;
  logic [LANES-1:0][PP_BITS-1:0]    pl_d, pl_q, ph_d, ph_q;
  logic [LANES-1:0]                 neg_d, neg4_q, neg5_q;
  logic [DEN_BITS-1:0]              den4_q;
  vec_t                             f4_q, f5_q;
  logic [LANES-1:0][NUM_BITS-1:0]   prod, num_d, num_q;
  logic [DIV_BITS-1:0]              d5_q;
  logic                             dzero5_q;

  // |k_a| * |dot| split into two 26-bit halves of |dot|
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      kabs[a] = in_i.k[a][K_BITS-1] ? (K_BITS'(0) - in_i.k[a]) : in_i.k[a];
    end
    for (int p = 0; p < 2; p++) begin
      dabs[p] = in_i.dot[p][DOT_BITS-1] ? (DOT_BITS'(0) - in_i.dot[p]) : in_i.dot[p];
    end
    for (int l = 0; l < LANES; l++) begin
      pl_d[l]  = kabs[l/2][KMAG_BITS-1:0] * dabs[l%2][HALF_BITS-1:0];
      ph_d[l]  = kabs[l/2][KMAG_BITS-1:0] * dabs[l%2][DOTMAG_BITS-1:HALF_BITS];
      neg_d[l] = in_i.k[l/2][K_BITS-1] ^ in_i.dot[l%2][DOT_BITS-1];
    end
  end

  // rounding numerator 2|k_a||dot| + den
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      prod[l]  = {1'b0, ph_q[l], {HALF_BITS{1'b0}}} + NUM_BITS'(pl_q[l]);
      num_d[l] = {prod[l][NUM_BITS-2:0], 1'b0} + NUM_BITS'(den4_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      pl_q   <= pl_d;
      ph_q   <= ph_d;
      neg4_q <= neg_d;
      den4_q <= in_i.den;
      f4_q   <= in_i.f;
    end
    if (ld_i[1]) begin
      num_q    <= num_d;
      neg5_q   <= neg4_q;
      d5_q     <= {den4_q, 1'b0};
      dzero5_q <= (den4_q == '0);
      f5_q     <= f4_q;
    end
  end

  assign out_o.num   = num_q;
  assign out_o.neg   = neg5_q;
  assign out_o.d     = d5_q;
  assign out_o.dzero = dzero5_q;
  assign out_o.f     = f5_q;

endmodule

/* src/spk_divider.sv */
`timescale 1ns / 1ps

module spk_divider import spk_pkg::*; (
  input  logic                 clk_i,
  input  logic [DIV_STEPS-1:0] ld_i,
  input  div_in_t              in_i,
  output div_out_t             out_o
);

  // restoring division, one quotient bit per stage; quotient known below 2^QUO_BITS
  logic [LANES-1:0][DIV_BITS-1:0] rem_q  [DIV_STEPS];
  logic [LANES-1:0][QUO_BITS-1:0] quo_q  [DIV_STEPS];
  logic [LANES-1:0][QUO_BITS-1:0] low_q  [DIV_STEPS];
  logic [DIV_BITS-1:0]            d_q    [DIV_STEPS];
  logic [LANES-1:0]               neg_q  [DIV_STEPS];
  logic                           dzero_q[DIV_STEPS];
  vec_t                           f_q    [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [LANES-1:0][DIV_BITS-1:0] rem_in, rem_d;
    logic [LANES-1:0][QUO_BITS-1:0] quo_in, quo_d, low_in, low_d;
    logic [DIV_BITS-1:0]            d_in;
    logic [LANES-1:0]               neg_in;
    logic                           dzero_in;
    vec_t                           f_in;
    logic [LANES-1:0][DIV_BITS:0]   trial;
    logic [LANES-1:0]               ge;

    if (j == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_in[l] = DIV_BITS'(in_i.num[l][NUM_BITS-1:QUO_BITS]);
        assign low_in[l] = in_i.num[l][QUO_BITS-1:0];
        assign quo_in[l] = '0;
      end
      assign d_in     = in_i.d;
      assign neg_in   = in_i.neg;
      assign dzero_in = in_i.dzero;
      assign f_in     = in_i.f;
    end else begin : g_next
      assign rem_in   = rem_q[j-1];
      assign low_in   = low_q[j-1];
      assign quo_in   = quo_q[j-1];
      assign d_in     = d_q[j-1];
      assign neg_in   = neg_q[j-1];
      assign dzero_in = dzero_q[j-1];
      assign f_in     = f_q[j-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_in[l], low_in[l][QUO_BITS-1]};
        ge[l]    = trial[l] >= {1'b0, d_in};
        rem_d[l] = ge[l] ? DIV_BITS'(trial[l] - {1'b0, d_in}) : trial[l][DIV_BITS-1:0];
        quo_d[l] = {quo_in[l][QUO_BITS-2:0], ge[l]};
        low_d[l] = {low_in[l][QUO_BITS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld_i[j]) begin
        rem_q[j]   <= rem_d;
        quo_q[j]   <= quo_d;
        low_q[j]   <= low_d;
        d_q[j]     <= d_in;
        neg_q[j]   <= neg_in;
        dzero_q[j] <= dzero_in;
        f_q[j]     <= f_in;
      end
    end
  end

  assign out_o.q     = quo_q[DIV_STEPS-1];
  assign out_o.neg   = neg_q[DIV_STEPS-1];
  assign out_o.dzero = dzero_q[DIV_STEPS-1];
  assign out_o.f     = f_q[DIV_STEPS-1];

endmodule
